FILE: sv/urfp_pkg.sv
// urfp_pkg: types and constants shared by the ultrasonic range frame parser
// no dependencies
`default_nettype none

package urfp_pkg;

   localparam logic [7:0]  HDR_BYTE = 8'hFF;
   localparam logic [9:0]  IDLE_MAX = 10'd1023;
   localparam logic [15:0] BAD_DIST = 16'hFFFF;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_CKSUM = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [1:0] CSR_IDLE_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_MIN_DISTANCE = 2'd1;
   localparam logic [1:0] CSR_MAX_DISTANCE = 2'd2;

   localparam logic [9:0]  RST_IDLE_TIMEOUT = 10'd100;
   localparam logic [15:0] RST_MIN_DISTANCE = 16'd50;
   localparam logic [15:0] RST_MAX_DISTANCE = 16'd6000;

   typedef struct packed {
      logic       cmd;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] distance_mm;
      logic [1:0]  frame_status;
   } rsp_type;

   typedef struct packed {
      logic [9:0]  idle_timeout_ms;
      logic [15:0] min_distance;
      logic [15:0] max_distance;
   } cfg_type;

   typedef struct packed {
      logic    valid;
      rsp_type payload;
   } result_type;

endpackage

`default_nettype wire

FILE: sv/urfp_frame.sv
// urfp_frame: frame hunt, byte collection, idle timeout and result decode
// depends on urfp_pkg
`default_nettype none

module urfp_frame (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             go,
   input  wire urfp_pkg::req_type item,
   input  wire urfp_pkg::cfg_type cfg,
   output urfp_pkg::result_type  result
);
   import urfp_pkg::*;

   logic [1:0]  byte_count_ff, byte_count_in;
   logic [7:0]  running_sum_ff, running_sum_in;
   logic [7:0]  dist_high_ff, dist_high_in;
   logic [7:0]  dist_low_ff, dist_low_in;
   logic [9:0]  idle_ms_ff, idle_ms_in;
   logic [9:0]  idle_inc;
   logic [7:0]  sum_add;
   logic [15:0] frame_mm;

   assign idle_inc = (idle_ms_ff < IDLE_MAX) ? idle_ms_ff + 10'd1 : idle_ms_ff;
   assign sum_add  = running_sum_ff + item.rx_byte;
   assign frame_mm = {dist_high_ff, dist_low_ff};

   always_comb begin
      byte_count_in  = byte_count_ff;
      running_sum_in = running_sum_ff;
      dist_high_in   = dist_high_ff;
      dist_low_in    = dist_low_ff;
      idle_ms_in     = idle_ms_ff;
      result         = '0;
      if (go) begin
         if (item.cmd == CMD_TICK) begin
            idle_ms_in = idle_inc;
            if (byte_count_ff != 2'd0 && idle_inc > cfg.idle_timeout_ms) begin
               byte_count_in = 2'd0;
            end
         end else begin
            idle_ms_in = '0;
            case (byte_count_ff)
               2'd0: begin
                  if (item.rx_byte == HDR_BYTE) begin
                     running_sum_in = item.rx_byte;
                     byte_count_in  = 2'd1;
                  end
               end
               2'd1: begin
                  dist_high_in   = item.rx_byte;
                  running_sum_in = sum_add;
                  byte_count_in  = 2'd2;
               end
               2'd2: begin
                  dist_low_in    = item.rx_byte;
                  running_sum_in = sum_add;
                  byte_count_in  = 2'd3;
               end
               default: begin
                  byte_count_in = 2'd0;
                  result.valid  = 1'b1;
                  if (item.rx_byte != running_sum_ff) begin
                     result.payload.frame_status = STATUS_CKSUM;
                  end else if (frame_mm == BAD_DIST || frame_mm < cfg.min_distance
                               || frame_mm > cfg.max_distance) begin
                     result.payload.frame_status = STATUS_RANGE;
                  end else begin
                     result.payload.frame_status = STATUS_OK;
                     result.payload.distance_mm  = frame_mm;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= '0;
         running_sum_ff <= '0;
         dist_high_ff   <= '0;
         dist_low_ff    <= '0;
         idle_ms_ff     <= '0;
      end else begin
         byte_count_ff  <= byte_count_in;
         running_sum_ff <= running_sum_in;
         dist_high_ff   <= dist_high_in;
         dist_low_ff    <= dist_low_in;
         idle_ms_ff     <= idle_ms_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/urfp_rsp_buf.sv
// urfp_rsp_buf: result register that holds a transaction until it is taken
// depends on urfp_pkg
`default_nettype none

module urfp_rsp_buf (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire urfp_pkg::result_type result,
   output logic                     can_take,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output urfp_pkg::rsp_type        rsp_payload
);
   import urfp_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign can_take = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      data_in  = data_ff;
      if (result.valid) begin
         valid_in = 1'b1;
         data_in  = result.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

`default_nettype wire

FILE: sv/ultrasonic_range_frame_parser.sv
// ultrasonic_range_frame_parser: top level, csr registers, input register
// depends on urfp_pkg, urfp_frame, urfp_rsp_buf
//
//   channel | direction | payload           | accepted when
//   req     | in        | cmd, rx_byte      | req_valid & req_ready
//   rsp     | out       | distance, status  | rsp_valid & rsp_ready
//   csr     | in        | index, wdata      | csr_valid & csr_ready
//
// one transaction per cycle while no result is held: input register, frame logic, result register
// rsp_valid rises once the checksum byte has passed the input and result registers
// synchronous reset clears frame state, idle count and csr values to defaults
// a held result stalls the frame logic and, with the input register full, drops req_ready
// csr_ready is always high
`default_nettype none

module ultrasonic_range_frame_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire urfp_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output urfp_pkg::rsp_type      rsp_payload,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [15:0]       csr_wdata
);
   import urfp_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       in_valid_ff, in_valid_in;
   req_type    in_item_ff, in_item_in;
   logic       can_take;
   logic       process_go;
   result_type frm_result;

   assign csr_ready  = 1'b1;
   assign process_go = in_valid_ff && can_take;
   assign req_ready  = !in_valid_ff || process_go;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_IDLE_TIMEOUT: cfg_in.idle_timeout_ms = csr_wdata[9:0];
            CSR_MIN_DISTANCE: cfg_in.min_distance    = csr_wdata;
            CSR_MAX_DISTANCE: cfg_in.max_distance    = csr_wdata;
            default:          cfg_in                 = cfg_ff;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff && !process_go;
      in_item_in  = in_item_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_item_in  = req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_timeout_ms <= RST_IDLE_TIMEOUT;
         cfg_ff.min_distance    <= RST_MIN_DISTANCE;
         cfg_ff.max_distance    <= RST_MAX_DISTANCE;
         in_valid_ff            <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   urfp_frame u_frame (
      .clock  (clock),
      .reset  (reset),
      .go     (process_go),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (frm_result)
   );

   urfp_rsp_buf u_rsp_buf (
      .clock       (clock),
      .reset       (reset),
      .result      (frm_result),
      .can_take    (can_take),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   a_result_only_when_processing: assert property (@(posedge clock) disable iff (reset)
      frm_result.valid |-> process_go)
      else $error("frame result without processing");

   a_stalled_item_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !process_go |=> in_valid_ff && $stable(in_item_ff))
      else $error("stalled input item lost");

   a_error_zero_distance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_status != STATUS_OK |-> rsp_payload.distance_mm == 16'd0)
      else $error("error result carries a distance");

   a_result_from_byte: assert property (@(posedge clock) disable iff (reset)
      frm_result.valid |-> in_item_ff.cmd == CMD_BYTE)
      else $error("tick produced a result");

endmodule

`default_nettype wire
